// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the blocks that check themselves.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ----- sv/m3ma_pkg.sv -----
// ---------------------------------------------------------------------------
// m3ma_pkg
// Shared types for the median-of-three moving-average filter.
// ---------------------------------------------------------------------------
`default_nettype none

package m3ma_pkg;

  // position within a group of three samples
  typedef enum logic [1:0] {
    GRP_NONE = 2'd0,
    GRP_ONE  = 2'd1,
    GRP_TWO  = 2'd2
  } grp_t;

  // status of the filter core, seen by the mean stage and the top level
  typedef struct packed {
    logic primed;  // ring has been filled once
    logic busy;    // input register holds a word
    logic pend;    // running sum holds a mean waiting for the output stage
  } m3ma_ctl_t;

endpackage

`default_nettype wire

// ----- sv/m3ma_ram.sv -----
// ---------------------------------------------------------------------------
// m3ma_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module m3ma_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/m3ma_core.sv -----
// ---------------------------------------------------------------------------
// m3ma_core
// Input register, group-of-three median, ring of medians and running sum.
// ---------------------------------------------------------------------------
`default_nettype none

module m3ma_core import m3ma_pkg::*; #(
  parameter int RING_DEPTH  = 8,
  parameter int SAMPLE_BITS = 12,
  parameter int SUM_W       = SAMPLE_BITS + $clog2(RING_DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic                   sample_valid,
  output logic                        sample_stall,
  input  wire logic                   pend_move,
  output logic      [SUM_W-1:0]       sum,
  output m3ma_ctl_t                   ctl
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int MED_W = SAMPLE_BITS + 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  // input register
  logic                   a_valid;
  logic [SAMPLE_BITS-1:0] a_sample;

  // filter state
  logic [IDX_W-1:0]       widx;
  logic [IDX_W-1:0]       widx_next;
  logic                   primed;
  grp_t                   gcount;
  logic [SAMPLE_BITS-1:0] g0;
  logic [SAMPLE_BITS-1:0] g1;
  logic                   pend;

  logic                   a_move;
  logic                   proc;
  logic                   is_median;
  logic                   ring_we;
  logic [SAMPLE_BITS-1:0] ring_wdata;
  logic [SAMPLE_BITS-1:0] ring_old;
  logic [SAMPLE_BITS-1:0] hi;
  logic [SAMPLE_BITS-1:0] lo;
  logic [MED_W-1:0]       med_wide;
  logic [SAMPLE_BITS-1:0] med;

  // handshake: the input word moves on unless a mean is stuck in the sum
  assign a_move       = !pend || pend_move;
  assign sample_stall = a_valid && !a_move;
  assign proc         = a_valid && a_move;
  assign is_median    = primed && (gcount == GRP_TWO);

  // median of three as sum minus maximum minus minimum
  always_comb begin
    hi = g0;
    lo = g0;
    if (g1 > hi) hi = g1;
    if (a_sample > hi) hi = a_sample;
    if (g1 < lo) lo = g1;
    if (a_sample < lo) lo = a_sample;
    med_wide = MED_W'(g0) + MED_W'(g1) + MED_W'(a_sample) - MED_W'(hi) - MED_W'(lo);
    med      = med_wide[SAMPLE_BITS-1:0];
  end

  // ring write: raw samples while priming, medians afterwards
  assign ring_we    = proc && (!primed || is_median);
  assign ring_wdata = primed ? med : a_sample;
  assign widx_next  = (widx == LAST_IDX) ? '0 : widx + IDX_W'(1);

  // ring of medians; the entry about to be replaced is prefetched at widx
  m3ma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (widx),
    .wdata (ring_wdata),
    .raddr (widx),
    .rdata (ring_old)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (sample_valid && !sample_stall) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      a_sample <= sample;
    end
  end

  // control state: fill pointer, prime flag, group position, pending mean, running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      widx   <= '0;
      primed <= 1'b0;
      gcount <= GRP_NONE;
      pend   <= 1'b0;
      sum    <= '0;
    end else begin
      if (proc && is_median) begin
        pend <= 1'b1;
      end else if (pend_move) begin
        pend <= 1'b0;
      end
      if (proc) begin
        if (!primed) begin
          widx <= widx_next;
          sum  <= sum + SUM_W'(a_sample);
          if (widx == LAST_IDX) begin
            primed <= 1'b1;
          end
        end else begin
          case (gcount)
            GRP_NONE: gcount <= GRP_ONE;
            GRP_ONE:  gcount <= GRP_TWO;
            GRP_TWO: begin
              gcount <= GRP_NONE;
              widx   <= widx_next;
              sum    <= sum - SUM_W'(ring_old) + SUM_W'(med);
            end
            default:  gcount <= GRP_NONE;
          endcase
        end
      end
    end
  end

  // group sample holding registers
  always_ff @(posedge clk) begin
    if (proc && primed && (gcount == GRP_NONE)) begin
      g0 <= a_sample;
    end
    if (proc && primed && (gcount == GRP_ONE)) begin
      g1 <= a_sample;
    end
  end

  assign ctl.primed = primed;
  assign ctl.busy   = a_valid;
  assign ctl.pend   = pend;

endmodule

`default_nettype wire

// ----- sv/m3ma_mean.sv -----
// ---------------------------------------------------------------------------
// m3ma_mean
// Output stage: divides the ring sum by the ring depth and holds the result.
// ---------------------------------------------------------------------------
`default_nettype none

module m3ma_mean import m3ma_pkg::*; #(
  parameter int RING_DEPTH  = 8,
  parameter int SAMPLE_BITS = 12,
  parameter int SUM_W       = SAMPLE_BITS + $clog2(RING_DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [SUM_W-1:0]       sum,
  input  wire m3ma_ctl_t              ctl,
  output logic                        pend_move,
  output logic      [SAMPLE_BITS-1:0] filtered,
  output logic                        filtered_valid,
  input  wire logic                   filtered_stall
);

  // floor(x / D) == (x * ceil(2^S / D)) >> S for all x below 2^SUM_W,
  // with S = SUM_W + ceil(log2 D)
  localparam int SHIFT   = SUM_W + $clog2(RING_DEPTH);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  logic [PROD_W-1:0] prod;

  // reciprocal multiply straight from the sum register
  assign prod      = PROD_W'(sum) * PROD_W'(RECIP);
  assign pend_move = !filtered_valid || !filtered_stall;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_valid <= 1'b0;
    end else if (pend_move) begin
      filtered_valid <= ctl.pend;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move && ctl.pend) begin
      filtered <= prod[SHIFT +: SAMPLE_BITS];
    end
  end

endmodule

`default_nettype wire

// ----- sv/median3_moving_average_filter.sv -----
// ---------------------------------------------------------------------------
// median3_moving_average_filter
// Median-of-three prefilter feeding a moving average over a ring of medians.
// ---------------------------------------------------------------------------
// Usage:
//   sample channel (sample, sample_valid, sample_stall) takes one raw ADC
//   word per accepted cycle; filtered channel (filtered, filtered_valid,
//   filtered_stall) gives the truncated mean of the ring of medians.
//   After reset the first RING_DEPTH words fill the ring and give nothing.
//   From then on every third word closes a group; its median replaces the
//   oldest ring entry and one mean word is produced.
//   Throughput: one word per unstalled cycle, one result per three words.
//   Path: after the third word of a group is accepted, its mean passes
//   through the input register, the running-sum update and the reciprocal
//   multiply into the output register, where it appears on filtered.
//   The running sum is kept in a register and the replaced ring entry is
//   read ahead from the ring RAM, so each word is one add/subtract.
//   Reset (rst, synchronous) clears the pipeline, the fill pointer and the
//   group position; the ring contents need no clearing.
//   While filtered_stall holds a result, up to four more words are taken
//   (the three of the next group plus one in the input register) before
//   sample_stall rises.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module median3_moving_average_filter import m3ma_pkg::*; #(
  parameter int RING_DEPTH  = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic                   sample_valid,
  output logic                        sample_stall,
  output logic      [SAMPLE_BITS-1:0] filtered,
  output logic                        filtered_valid,
  input  wire logic                   filtered_stall
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(RING_DEPTH);

  logic [SUM_W-1:0] sum;
  logic             pend_move;
  m3ma_ctl_t        ctl;

  // median filter, ring and running sum
  m3ma_core #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .pend_move    (pend_move),
    .sum          (sum),
    .ctl          (ctl)
  );

  // divide by depth and output register
  m3ma_mean #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_mean (
    .clk            (clk),
    .rst            (rst),
    .sum            (sum),
    .ctl            (ctl),
    .pend_move      (pend_move),
    .filtered       (filtered),
    .filtered_valid (filtered_valid),
    .filtered_stall (filtered_stall)
  );

  // a mean is only formed once the ring is full
  `ASSERT_SAME(a_pend_primed, clk, rst, ctl.pend, ctl.primed)
  // input backs up only when every stage behind it is full and blocked
  `ASSERT_SAME(a_stall_full, clk, rst, sample_stall,
               ctl.busy && ctl.pend && filtered_valid && filtered_stall)
  // a pending mean that can move shows up on the output next cycle
  `ASSERT_NEXT(a_pend_out, clk, rst, ctl.pend && pend_move, filtered_valid)
  // nothing leaves the block before priming is done
  `ASSERT_SAME(a_out_primed, clk, rst, filtered_valid, ctl.primed)

endmodule

`default_nettype wire
